FILE: src/cse_pkg.sv
// Shared types and constants for the CAN signal extractor.
package cse_pkg;

	localparam int unsigned PAYLOAD_BYTES = 8;
	localparam int unsigned PAYLOAD_W     = 64;
	localparam int unsigned LEN_W         = 7;
	localparam int unsigned START_W       = 6;
	localparam int unsigned FACTOR_W      = 32;
	localparam int unsigned OFFSET_W      = 64;
	localparam int unsigned DLC_W         = 4;
	localparam int unsigned CFG_IDX_W     = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_BIT     = 3'd0,
		REG_SIGNAL_LENGTH = 3'd1,
		REG_LITTLE_ENDIAN = 3'd2,
		REG_IS_SIGNED     = 3'd3,
		REG_SCALE_FACTOR  = 3'd4,
		REG_SCALE_OFFSET  = 3'd5
	} cse_reg_idx_t;

	typedef struct packed {
		logic [START_W-1:0]         start_bit;
		logic [LEN_W-1:0]           signal_length;
		logic                       little_endian;
		logic                       is_signed;
		logic signed [FACTOR_W-1:0] scale_factor;
		logic signed [OFFSET_W-1:0] scale_offset;
	} cse_cfg_t;

endpackage

FILE: src/cse_byte_lane.sv
// One byte lane: picks the payload byte that holds a given step of the signal.
module cse_byte_lane import cse_pkg::*; #(
	parameter int unsigned LANE = 0
) (
	input  logic [PAYLOAD_W-1:0] payload,
	input  logic [2:0]           start_byte,
	input  logic                 little_endian,
	output logic [7:0]           lane_byte
);

	localparam logic [3:0] STEP = 4'(LANE);

	logic [3:0] idx;

	always_comb begin
		if (little_endian) begin
			idx = {1'b0, start_byte} + STEP;
		end else begin
			idx = {1'b0, start_byte} - STEP;
		end
		if (idx[3]) begin
			lane_byte = 8'd0;
		end else begin
			lane_byte = payload[{idx[2:0], 3'b000} +: 8];
		end
	end

endmodule

FILE: src/cse_merge.sv
// Merges the lane bytes into the raw signal: aligns, masks and sign-extends.
module cse_merge import cse_pkg::*; (
	input  logic [PAYLOAD_W-1:0] lane_word,
	input  logic                 fit,
	input  logic [2:0]           start_off,
	input  logic [LEN_W-1:0]     len,
	input  logic                 is_signed,
	output logic [PAYLOAD_W-1:0] raw
);

	logic [PAYLOAD_W-1:0] shifted;
	logic [PAYLOAD_W-1:0] mask;
	logic [PAYLOAD_W-1:0] bits;
	logic [LEN_W-1:0]     msb_pos;

	always_comb begin
		shifted = lane_word >> start_off;
		if (len == LEN_W'(PAYLOAD_W)) begin
			mask = '1;
		end else begin
			mask = (PAYLOAD_W'(1) << len[5:0]) - PAYLOAD_W'(1);
		end
		bits    = shifted & mask;
		msb_pos = len - LEN_W'(1);
		if (!fit || len == '0) begin
			raw = '0;
		end else if (is_signed && bits[msb_pos[5:0]]) begin
			raw = bits | ~mask;
		end else begin
			raw = bits;
		end
	end

endmodule

FILE: src/cse_scaler.sv
// Pipelined scaling of the raw value: raw times factor plus offset, saturated.
module cse_scaler import cse_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cse_cfg_t                    cfg,
	input  logic                        in_vld,
	output logic                        in_rdy,
	input  logic [PAYLOAD_W-1:0]        in_raw,
	input  logic                        in_fit,
	output logic                        out_vld,
	input  logic                        out_stall,
	output logic [PAYLOAD_W-1:0]        out_raw,
	output logic                        out_fit,
	output logic signed [OFFSET_W-1:0]  out_eng
);

	localparam int unsigned MAG_W = PAYLOAD_W + FACTOR_W;
	localparam int unsigned SUM_W = MAG_W + 2;

	logic v_s3, v_s4, v_s5, v_s6, v_s7;
	logic rdy_s3, rdy_s4, rdy_s5, rdy_s6, rdy_s7;

	logic [PAYLOAD_W-1:0] raw_s3, raw_s4, raw_s5, raw_s6, raw_s7;
	logic                 fit_s3, fit_s4, fit_s5, fit_s6, fit_s7;
	logic                 neg_s3, neg_s4, neg_s5;
	logic [PAYLOAD_W-1:0] rmag_s3;
	logic [FACTOR_W-1:0]  fmag_s3;
	logic [63:0]          p0_s4, p1_s4;
	logic [MAG_W-1:0]     mag_s5;
	logic [MAG_W:0]       prod_s6;
	logic [OFFSET_W-1:0]  eng_s7;

	logic                 rneg;
	logic                 fneg;
	logic [SUM_W-1:0]     sum;
	logic [SUM_W-OFFSET_W:0] sum_hi;

	assign rdy_s7 = !v_s7 || !out_stall;
	assign rdy_s6 = !v_s6 || rdy_s7;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign in_rdy = rdy_s3;

	assign rneg = cfg.is_signed && in_raw[PAYLOAD_W-1];
	assign fneg = cfg.scale_factor[FACTOR_W-1];

	always_comb begin
		sum    = {prod_s6[MAG_W], prod_s6} +
		         {{(SUM_W-OFFSET_W){cfg.scale_offset[OFFSET_W-1]}}, cfg.scale_offset};
		sum_hi = sum[SUM_W-1:OFFSET_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s3) v_s3 <= in_vld;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_vld) begin
			raw_s3  <= in_raw;
			fit_s3  <= in_fit;
			neg_s3  <= rneg ^ fneg;
			rmag_s3 <= rneg ? (~in_raw + PAYLOAD_W'(1)) : in_raw;
			fmag_s3 <= fneg ? (~cfg.scale_factor + FACTOR_W'(1)) : cfg.scale_factor;
		end
		if (rdy_s4 && v_s3) begin
			raw_s4 <= raw_s3;
			fit_s4 <= fit_s3;
			neg_s4 <= neg_s3;
			p0_s4  <= rmag_s3[31:0] * fmag_s3;
			p1_s4  <= rmag_s3[63:32] * fmag_s3;
		end
		if (rdy_s5 && v_s4) begin
			raw_s5 <= raw_s4;
			fit_s5 <= fit_s4;
			neg_s5 <= neg_s4;
			mag_s5 <= {32'd0, p0_s4} + {p1_s4, 32'd0};
		end
		if (rdy_s6 && v_s5) begin
			raw_s6  <= raw_s5;
			fit_s6  <= fit_s5;
			prod_s6 <= neg_s5 ? (~{1'b0, mag_s5} + (MAG_W+1)'(1)) : {1'b0, mag_s5};
		end
		if (rdy_s7 && v_s6) begin
			raw_s7 <= raw_s6;
			fit_s7 <= fit_s6;
			if (&sum_hi || !(|sum_hi)) begin
				eng_s7 <= sum[OFFSET_W-1:0];
			end else if (sum[SUM_W-1]) begin
				eng_s7 <= {1'b1, {(OFFSET_W-1){1'b0}}};
			end else begin
				eng_s7 <= {1'b0, {(OFFSET_W-1){1'b1}}};
			end
		end
	end

	assign out_vld = v_s7;
	assign out_raw = raw_s7;
	assign out_fit = fit_s7;
	assign out_eng = signed'(eng_s7);

endmodule

FILE: src/can_signal_extractor_unit.sv
// CAN signal extractor: takes one signal out of each frame payload and scales it.
//
// The block accepts one frame payload per clock cycle while in_stall is low
// and returns one result per frame, with results in order. Eight byte lanes pick
// the signal's bytes in parallel (ascending for Intel order, descending for
// Motorola order), a merge stage aligns, masks and sign-extends the raw value,
// and a five-stage pipeline splits the 64 by 32 bit scaling multiply into two
// 32 by 32 bit products before the offset add and saturation. Configuration
// registers must only be written while no frame is in flight.
module can_signal_extractor_unit import cse_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [63:0]                 cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [PAYLOAD_W-1:0]        payload,
	input  logic [DLC_W-1:0]            payload_len,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [PAYLOAD_W-1:0]        raw_value,
	output logic                        signal_valid,
	output logic signed [OFFSET_W-1:0]  eng_value
);

	cse_cfg_t cfg_q;

	logic [LEN_W-1:0]     len;
	logic [2:0]           start_off;
	logic [2:0]           start_byte;
	logic [3:0]           nbytes;
	logic [DLC_W-1:0]     dlc;
	logic                 fit;
	logic [PAYLOAD_W-1:0] lane_word;
	logic [PAYLOAD_W-1:0] merged_raw;
	logic [LEN_W+1:0]     span;

	logic                 v_s1, v_s2;
	logic                 rdy_s1, rdy_s2;
	logic                 sc_rdy;
	logic [PAYLOAD_W-1:0] word_s1;
	logic                 fit_s1;
	logic [PAYLOAD_W-1:0] raw_s2;
	logic                 fit_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_bit     <= '0;
			cfg_q.signal_length <= '0;
			cfg_q.little_endian <= 1'b1;
			cfg_q.is_signed     <= 1'b0;
			cfg_q.scale_factor  <= FACTOR_W'(65536);
			cfg_q.scale_offset  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START_BIT:     cfg_q.start_bit     <= cfg_data[START_W-1:0];
				REG_SIGNAL_LENGTH: cfg_q.signal_length <= cfg_data[LEN_W-1:0];
				REG_LITTLE_ENDIAN: cfg_q.little_endian <= cfg_data[0];
				REG_IS_SIGNED:     cfg_q.is_signed     <= cfg_data[0];
				REG_SCALE_FACTOR:  cfg_q.scale_factor  <= cfg_data[FACTOR_W-1:0];
				REG_SCALE_OFFSET:  cfg_q.scale_offset  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		len        = (cfg_q.signal_length > LEN_W'(64)) ? LEN_W'(64) : cfg_q.signal_length;
		start_off  = cfg_q.start_bit[2:0];
		start_byte = cfg_q.start_bit[5:3];
		span       = (LEN_W+2)'(start_off) + (LEN_W+2)'(len) + (LEN_W+2)'(7);
		nbytes     = (len == '0) ? 4'd1 : span[6:3];
		dlc        = (payload_len > DLC_W'(PAYLOAD_BYTES)) ? DLC_W'(PAYLOAD_BYTES) : payload_len;
		if (cfg_q.little_endian) begin
			fit = ({2'b00, start_byte} + {1'b0, nbytes}) <= {1'b0, dlc};
		end else begin
			fit = ({1'b0, start_byte} < dlc) &&
			      (({1'b0, start_byte} + 4'd1) >= nbytes);
		end
	end

	for (genvar i = 0; i < PAYLOAD_BYTES; i++) begin : g_lane
		cse_byte_lane #(
			.LANE(i)
		) u_lane (
			.payload      (payload),
			.start_byte   (start_byte),
			.little_endian(cfg_q.little_endian),
			.lane_byte    (lane_word[i*8 +: 8])
		);
	end

	assign rdy_s2   = !v_s2 || sc_rdy;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			word_s1 <= lane_word;
			fit_s1  <= fit;
		end
		if (rdy_s2 && v_s1) begin
			raw_s2 <= merged_raw;
			fit_s2 <= fit_s1;
		end
	end

	cse_merge u_merge (
		.lane_word(word_s1),
		.fit      (fit_s1),
		.start_off(start_off),
		.len      (len),
		.is_signed(cfg_q.is_signed),
		.raw      (merged_raw)
	);

	cse_scaler u_scaler (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_vld   (v_s2),
		.in_rdy   (sc_rdy),
		.in_raw   (raw_s2),
		.in_fit   (fit_s2),
		.out_vld  (out_valid),
		.out_stall(out_stall),
		.out_raw  (raw_value),
		.out_fit  (signal_valid),
		.out_eng  (eng_value)
	);

endmodule
